### design/oah_pkg.sv
// Shared types and constants for the open-addressing hash set.
// Used by oah_rem, oah_mem, open_addressing_hash_set_unit, oah_checker and tb; depends on nothing.
package oah_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned KeyW = 32;
  localparam int unsigned SizeW = 11;
  localparam int unsigned StepW = 10;
  localparam int unsigned SlotW = 10;
  localparam int unsigned CntW = 11;
  localparam int unsigned CfgW = 11;
  localparam int unsigned StepDivW = 12;
  localparam int unsigned RemBpc = 4;

  localparam logic [SizeW-1:0] SizeReset = 11'd1021;
  localparam logic [StepW-1:0] StepReset = 10'd1;
  localparam logic [SizeW-1:0] SizeMin = 11'd2;

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeDelete = 2'd1,
    ModeFind   = 2'd2,
    ModeClear  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusPresent  = 2'd2,
    StatusFull     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MarkEmpty   = 2'd0,
    MarkUsed    = 2'd1,
    MarkDeleted = 2'd2
  } mark_e;

  typedef enum logic {
    RegTableSize = 1'b0,
    RegProbeStep = 1'b1
  } reg_idx_e;

  typedef struct packed {
    mark_e            mark;
    logic [KeyW-1:0]  key;
  } entry_t;

endpackage

### design/oah_mem.sv
// Slot memory holding one mark and one key per slot.
// Simple dual-port synchronous RAM, registered read; uses oah_pkg.
module oah_mem #(
  parameter int unsigned Depth = oah_pkg::DefCapacity,
  parameter int unsigned AddrW = $clog2(oah_pkg::DefCapacity)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  oah_pkg::entry_t     wr_data_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output oah_pkg::entry_t     rd_data_o
);
  import oah_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/oah_rem.sv
// Iterative restoring remainder unit, four dividend bits per cycle.
// Computes an unsigned dividend modulo an 11-bit divisor; uses oah_pkg.
module oah_rem #(
  parameter int unsigned DivW = oah_pkg::KeyW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DivW-1:0]            dividend_i,
  input  logic [oah_pkg::SizeW-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [oah_pkg::SizeW-1:0]  rem_o
);
  import oah_pkg::*;

  localparam int unsigned Iter = DivW / RemBpc;
  localparam int unsigned IterCntW = (Iter > 1) ? $clog2(Iter) : 1;

  logic                busy_q, busy_d;
  logic [IterCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]     dvd_q, dvd_d;
  logic [SizeW-1:0]    div_q, div_d;
  logic [SizeW-1:0]    rem_q, rem_d;
  logic [SizeW-1:0]    part;
  logic [SizeW:0]      trial;

  always_comb begin
    part = rem_q;
    trial = '0;
    for (int j = 0; j < int'(RemBpc); j++) begin
      trial = {part, dvd_q[DivW-1-j]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      part = trial[SizeW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    div_d = div_q;
    rem_d = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = IterCntW'(Iter - 1);
      dvd_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << RemBpc;
      rem_d = part;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o = rem_q;

endmodule

### design/open_addressing_hash_set_unit.sv
// Open-addressing hash set of signed 32-bit keys with linear probing and tombstones.
// Insert, delete and find compute the home slot and step remainders in two separate
// four-bit-per-cycle remainder units, then probe the slot memory slot by slot.
// done_o pulses in the cycle after the last probe; a new transfer can be taken in that cycle.
// Clear and reset both run a clearing pass over all CAPACITY slots with busy_o high.
// The result strobe cannot be stalled; uses oah_pkg, oah_rem and oah_mem.
module open_addressing_hash_set_unit #(
  parameter int unsigned CAPACITY = oah_pkg::DefCapacity
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [oah_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 mode_i,
  input  logic signed [31:0]         key_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [oah_pkg::SlotW-1:0]  slot_o,
  output logic [oah_pkg::CntW-1:0]   comparisons_o,
  output logic [oah_pkg::CntW-1:0]   occupancy_o
);
  import oah_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [31:0] CapWord = 32'(CAPACITY);

  typedef enum logic [1:0] {
    StSweep,
    StIdle,
    StHash,
    StProbe
  } state_e;

  state_e            state_q;
  logic [SizeW-1:0]  table_size_q;
  logic [StepW-1:0]  probe_step_q;
  logic [CntW-1:0]   used_q;
  logic [AddrW-1:0]  clr_q;
  logic              clr_op_q;
  mode_e             mode_q;
  logic [KeyW-1:0]   key_q;
  logic              neg_q;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  step_q;
  logic [SizeW-1:0]  pos_q;
  logic [CntW-1:0]   probe_cnt_q;
  logic [CntW-1:0]   cmps_q;
  logic              free_q;
  logic [SizeW-1:0]  free_pos_q;
  logic              done_q;
  status_e           status_q;
  logic [SlotW-1:0]  slot_q;
  logic [CntW-1:0]   comparisons_q;

  logic              accept;
  logic [SizeW-1:0]  eff_size;
  logic [KeyW-1:0]   key_mag;
  logic              key_busy, step_busy;
  logic [SizeW-1:0]  key_rem, step_rem;
  logic              hash_ready;
  logic [SizeW-1:0]  home;
  logic [SizeW-1:0]  step_eff;
  logic [SizeW:0]    pos_sum;
  logic [SizeW-1:0]  nxt;
  entry_t            rd_ent;
  logic              is_empty, hit, last, term, free_any;
  logic [CntW-1:0]   cmps_new;
  logic [SizeW-1:0]  free_pos_new;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  entry_t            wr_data;
  logic [AddrW-1:0]  rd_addr;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    if (table_size_q < SizeMin) begin
      eff_size = SizeMin;
    end else if ({21'b0, table_size_q} > CapWord) begin
      eff_size = SizeW'(CAPACITY);
    end else begin
      eff_size = table_size_q;
    end
  end

  assign key_mag = key_i[31] ? (~key_i + 1'b1) : key_i;

  oah_rem #(.DivW(KeyW)) u_key_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (key_mag),
    .divisor_i  (eff_size),
    .busy_o     (key_busy),
    .rem_o      (key_rem)
  );

  oah_rem #(.DivW(StepDivW)) u_step_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i ({{(StepDivW - StepW){1'b0}}, probe_step_q}),
    .divisor_i  (eff_size),
    .busy_o     (step_busy),
    .rem_o      (step_rem)
  );

  assign hash_ready = !key_busy && !step_busy;
  assign home = (neg_q && (key_rem != '0)) ? (size_q - key_rem) : key_rem;
  assign step_eff = (step_rem == '0) ? SizeW'(1) : step_rem;

  assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
  assign nxt = (pos_sum >= {1'b0, size_q}) ? SizeW'(pos_sum - {1'b0, size_q})
                                           : pos_sum[SizeW-1:0];

  assign rd_addr = (state_q == StHash) ? AddrW'(home) : AddrW'(nxt);

  assign is_empty = (rd_ent.mark == MarkEmpty);
  assign hit = (rd_ent.mark == MarkUsed) && (rd_ent.key == key_q);
  assign last = (probe_cnt_q == CntW'(size_q - 1'b1));
  assign term = is_empty || hit || last;
  assign cmps_new = is_empty ? cmps_q : (cmps_q + 1'b1);
  assign free_any = free_q || (rd_ent.mark != MarkUsed);
  assign free_pos_new = free_q ? free_pos_q : pos_q;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = AddrW'(pos_q);
    wr_data = '{mark: MarkEmpty, key: '0};
    if (state_q == StSweep) begin
      wr_en = 1'b1;
      wr_addr = clr_q;
    end else if ((state_q == StProbe) && term) begin
      if ((mode_q == ModeInsert) && !hit && (used_q < size_q) && free_any) begin
        wr_en = 1'b1;
        wr_addr = AddrW'(free_pos_new);
        wr_data = '{mark: MarkUsed, key: key_q};
      end else if ((mode_q == ModeDelete) && hit) begin
        wr_en = 1'b1;
        wr_data = '{mark: MarkDeleted, key: key_q};
      end
    end
  end

  oah_mem #(.Depth(CAPACITY), .AddrW(AddrW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_ent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SizeReset;
      probe_step_q <= StepReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegTableSize: table_size_q <= cfg_wdata_i[SizeW-1:0];
        RegProbeStep: probe_step_q <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSweep;
      clr_q <= '0;
      clr_op_q <= 1'b0;
      used_q <= '0;
      done_q <= 1'b0;
      status_q <= StatusOk;
      slot_q <= '0;
      comparisons_q <= '0;
      mode_q <= ModeFind;
      key_q <= '0;
      neg_q <= 1'b0;
      size_q <= SizeMin;
      step_q <= '0;
      pos_q <= '0;
      probe_cnt_q <= '0;
      cmps_q <= '0;
      free_q <= 1'b0;
      free_pos_q <= '0;
    end else begin
      case (state_q)
        StSweep: begin
          if (clr_q == AddrW'(CAPACITY - 1)) begin
            clr_q <= '0;
            used_q <= '0;
            state_q <= StIdle;
            done_q <= clr_op_q;
            if (clr_op_q) begin
              status_q <= StatusOk;
              slot_q <= '0;
              comparisons_q <= '0;
            end
          end else begin
            clr_q <= clr_q + 1'b1;
            done_q <= 1'b0;
          end
        end
        StIdle: begin
          done_q <= 1'b0;
          if (start_i) begin
            mode_q <= mode_e'(mode_i);
            key_q <= key_i;
            neg_q <= key_i[31];
            size_q <= eff_size;
            if (mode_e'(mode_i) == ModeClear) begin
              clr_q <= '0;
              clr_op_q <= 1'b1;
              state_q <= StSweep;
            end else begin
              state_q <= StHash;
            end
          end
        end
        StHash: begin
          done_q <= 1'b0;
          if (hash_ready) begin
            pos_q <= home;
            step_q <= step_eff;
            probe_cnt_q <= '0;
            cmps_q <= '0;
            free_q <= 1'b0;
            state_q <= StProbe;
          end
        end
        StProbe: begin
          done_q <= term;
          if (!term) begin
            pos_q <= nxt;
            probe_cnt_q <= probe_cnt_q + 1'b1;
            cmps_q <= cmps_new;
            if (!free_q && (rd_ent.mark != MarkUsed)) begin
              free_q <= 1'b1;
              free_pos_q <= pos_q;
            end
          end else begin
            state_q <= StIdle;
            case (mode_q)
              ModeInsert: begin
                comparisons_q <= cmps_new;
                if (hit) begin
                  status_q <= StatusPresent;
                  slot_q <= pos_q[SlotW-1:0];
                end else if (used_q >= size_q) begin
                  status_q <= StatusFull;
                  slot_q <= '0;
                end else if (free_any) begin
                  status_q <= StatusOk;
                  slot_q <= free_pos_new[SlotW-1:0];
                  used_q <= used_q + 1'b1;
                end else begin
                  status_q <= StatusFull;
                  slot_q <= '0;
                end
              end
              ModeDelete: begin
                comparisons_q <= '0;
                if (hit) begin
                  status_q <= StatusOk;
                  slot_q <= pos_q[SlotW-1:0];
                  if (used_q != '0) begin
                    used_q <= used_q - 1'b1;
                  end
                end else begin
                  status_q <= StatusNotFound;
                  slot_q <= '0;
                end
              end
              default: begin
                comparisons_q <= cmps_new;
                if (hit) begin
                  status_q <= StatusOk;
                  slot_q <= pos_q[SlotW-1:0];
                end else begin
                  status_q <= StatusNotFound;
                  slot_q <= '0;
                end
              end
            endcase
          end
        end
        default: begin
          state_q <= StIdle;
          done_q <= 1'b0;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign slot_o = slot_q;
  assign comparisons_o = comparisons_q;
  assign occupancy_o = used_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(busy_o) || (used_q == $past(used_q)))
    else $error("occupancy changed while idle");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StatusFull || status_o == StatusNotFound)) |-> (slot_o == '0))
    else $error("slot reported on a failed operation");

endmodule

### tb/sv/oah_checker.sv
`timescale 1ns / 100ps
// Checker for the open-addressing hash set: it watches register writes, request and result
// transfers, keeps its own copy of the table and compares every result field. Uses oah_pkg.
module oah_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [oah_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [1:0]                 mode_i,
  input  logic [oah_pkg::KeyW-1:0]   key_i,
  input  logic                       done_i,
  input  logic [1:0]                 status_i,
  input  logic [oah_pkg::SlotW-1:0]  slot_i,
  input  logic [oah_pkg::CntW-1:0]   comparisons_i,
  input  logic [oah_pkg::CntW-1:0]   occupancy_i,
  output int unsigned                mismatch_cnt_o,
  output int unsigned                outstanding_o
);
  import oah_pkg::*;

  localparam int unsigned Depth = DefCapacity;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [CntW-1:0]   cmps;
    logic [CntW-1:0]   occ;
  } reply_t;

  mark_e            marks [Depth];
  logic [KeyW-1:0]  keys [Depth];
  logic [CntW-1:0]  used_slots;
  logic [SizeW-1:0] size_reg;
  logic [StepW-1:0] step_reg;
  reply_t           predicted_replies [$];
  reply_t           head;

  function automatic void empty_all();
    int unsigned i;
    for (i = 0; i < Depth; i++) marks[i] = MarkEmpty;
    used_slots = '0;
  endfunction

  function automatic int unsigned live_size();
    if (size_reg < SizeMin) return SizeMin;
    if (size_reg > Depth) return Depth;
    return size_reg;
  endfunction

  function automatic int unsigned live_stride(int unsigned size);
    int unsigned st;
    st = step_reg % size;
    return (st == 0) ? 1 : st;
  endfunction

  // Keys are signed, so negative keys wrap to a non-negative home slot.
  function automatic int unsigned home_of(logic [KeyW-1:0] k, int unsigned size);
    int unsigned mag;
    int unsigned r;
    if (!k[KeyW-1]) return k % size;
    mag = ~k + 1;
    r = mag % size;
    return (r == 0) ? 0 : size - r;
  endfunction

  function automatic bit locate(input logic [KeyW-1:0] k, input int unsigned size,
                                input int unsigned stride, output int unsigned where,
                                output int unsigned cmps);
    int unsigned pos;
    int unsigned i;
    pos = home_of(k, size);
    cmps = 0;
    where = 0;
    for (i = 0; i < size; i++) begin
      if (marks[pos] == MarkEmpty) return 1'b0;
      cmps++;
      if (marks[pos] == MarkUsed && keys[pos] == k) begin
        where = pos;
        return 1'b1;
      end
      pos += stride;
      if (pos >= size) pos -= size;
    end
    return 1'b0;
  endfunction

  function automatic reply_t run_hash_op(mode_e mode, logic [KeyW-1:0] k);
    reply_t      r;
    int unsigned size;
    int unsigned stride;
    int unsigned where;
    int unsigned cmps;
    int unsigned pos;
    int unsigned i;
    bit          hit;
    size = live_size();
    stride = live_stride(size);
    r = '{status: StatusOk, slot: '0, cmps: '0, occ: '0};
    case (mode)
      ModeInsert: begin
        hit = locate(k, size, stride, where, cmps);
        r.cmps = cmps[CntW-1:0];
        if (hit) begin
          r.status = StatusPresent;
          r.slot = where[SlotW-1:0];
        end else if (used_slots >= size) begin
          r.status = StatusFull;
        end else begin
          // A step that shares a factor with the size may never reach a free slot.
          r.status = StatusFull;
          pos = home_of(k, size);
          for (i = 0; i < size; i++) begin
            if (marks[pos] != MarkUsed) begin
              keys[pos] = k;
              marks[pos] = MarkUsed;
              used_slots++;
              r.status = StatusOk;
              r.slot = pos[SlotW-1:0];
              break;
            end
            pos += stride;
            if (pos >= size) pos -= size;
          end
        end
      end
      ModeDelete: begin
        hit = locate(k, size, stride, where, cmps);
        if (hit) begin
          marks[where] = MarkDeleted;
          if (used_slots > 0) used_slots--;
          r.slot = where[SlotW-1:0];
        end else begin
          r.status = StatusNotFound;
        end
      end
      ModeFind: begin
        hit = locate(k, size, stride, where, cmps);
        r.cmps = cmps[CntW-1:0];
        if (hit) r.slot = where[SlotW-1:0];
        else r.status = StatusNotFound;
      end
      default: empty_all();
    endcase
    r.occ = used_slots;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg = SizeReset;
      step_reg = StepReset;
      empty_all();
      predicted_replies.delete();
      mismatch_cnt_o = 0;
      outstanding_o = 0;
    end else begin
      if (done_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result transfer with nothing expected: status %0d, slot %0d",
                 status_i, slot_i);
          mismatch_cnt_o++;
        end else begin
          head = predicted_replies.pop_front();
          check_field("status", head.status, status_i);
          check_field("slot", head.slot, slot_i);
          check_field("comparisons", head.cmps, comparisons_i);
          check_field("occupancy", head.occ, occupancy_i);
        end
      end
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_idx_i) == RegTableSize) size_reg = cfg_wdata_i;
        else step_reg = cfg_wdata_i[StepW-1:0];
      end
      if (start_i && !busy_i) predicted_replies.push_back(run_hash_op(mode_e'(mode_i), key_i));
      outstanding_o = predicted_replies.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the hash set testbench: clock, reset, register writes and request stimulus with
// random idle gaps. Depends on oah_pkg, oah_checker and open_addressing_hash_set_unit.
module tb;
  import oah_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_idx_i;
  logic [CfgW-1:0]          cfg_wdata_i;
  logic                     start_i;
  logic                     busy_o;
  logic [1:0]               mode_i;
  logic signed [KeyW-1:0]   key_i;
  logic                     done_o;
  logic [1:0]               status_o;
  logic [SlotW-1:0]         slot_o;
  logic [CntW-1:0]          comparisons_o;
  logic [CntW-1:0]          occupancy_o;
  int unsigned              mismatches;
  int unsigned              outstanding;

  bit                       steady;
  int unsigned              pool_n;
  logic [KeyW-1:0]          key_pool [64];
  logic [KeyW-1:0]          extreme_keys [5] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                                 32'hFFFF_FFFF, 32'h0, 32'h1};
  logic [CfgW-1:0]          phase_size [18] = '{11'd2, 11'd3, 11'd5, 11'd7, 11'd11,
                                                11'd13, 11'd0, 11'd1, 11'd17, 11'd31,
                                                11'd8, 11'd16, 11'd61, 11'd1021,
                                                11'd1024, 11'd2047, 11'd101, 11'd5};
  logic [CfgW-1:0]          phase_step [18] = '{11'd1, 11'd2, 11'd3, 11'd6, 11'd4,
                                                11'd13, 11'd0, 11'd5, 11'd1023, 11'd7,
                                                11'd2, 11'd2047, 11'd11, 11'd1,
                                                11'd512, 11'd1000, 11'd37, 11'd3};

  always #1 clk_i = ~clk_i;

  open_addressing_hash_set_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .start_i,
    .busy_o,
    .mode_i,
    .key_i,
    .done_o,
    .status_o,
    .slot_o,
    .comparisons_o,
    .occupancy_o
  );

  oah_checker u_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .start_i,
    .busy_i         (busy_o),
    .mode_i,
    .key_i,
    .done_i         (done_o),
    .status_i       (status_o),
    .slot_i         (slot_o),
    .comparisons_i  (comparisons_o),
    .occupancy_i    (occupancy_o),
    .mismatch_cnt_o (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (steady || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 60);
    if (n != 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      mode_i = 2'($urandom);
      key_i = $urandom;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic issue(mode_e m, logic [KeyW-1:0] k);
    @(negedge clk_i);
    start_i = 1'b1;
    mode_i = m;
    key_i = k;
    do @(posedge clk_i); while (busy_o);
    idle_gap();
  endtask

  // Registers change only once every result is in and the unit has gone idle.
  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic fill_pool(int unsigned eff);
    int unsigned     i;
    int              v;
    logic [KeyW-1:0] base;
    pool_n = (eff < 30) ? 2 * eff + 3 : 48;
    base = $urandom;
    for (i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 3))
        0: key_pool[i] = $urandom;
        1: begin
          v = int'($urandom_range(0, 6 * eff)) - 3 * int'(eff);
          key_pool[i] = v;
        end
        2: key_pool[i] = extreme_keys[$urandom_range(0, 4)];
        default: key_pool[i] = base + eff * $urandom_range(0, 20);
      endcase
    end
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_n - 1)];
    return $urandom;
  endfunction

  task automatic run_phase(logic [CfgW-1:0] size_val, logic [CfgW-1:0] step_val);
    int unsigned eff;
    int unsigned n;
    int unsigned r;
    mode_e       m;
    settle();
    write_reg(RegTableSize, size_val);
    write_reg(RegProbeStep, step_val);
    eff = (size_val < SizeMin) ? SizeMin : (size_val > DefCapacity) ? DefCapacity : size_val;
    steady = ($urandom_range(0, 3) == 0);
    fill_pool(eff);
    if ($urandom_range(0, 1) == 0) issue(ModeClear, $urandom);
    n = (eff > 200) ? 20 : 60;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) m = ModeInsert;
      else if (r < 65) m = ModeDelete;
      else if (r < 96) m = ModeFind;
      else m = ModeClear;
      issue(m, pick_key());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_wdata_i = '0;
    start_i = 1'b0;
    mode_i = ModeInsert;
    key_i = '0;
    steady = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    settle();

    issue(ModeInsert, 32'hFFFF_FFFF);
    issue(ModeFind, 32'hFFFF_FFFF);
    issue(ModeInsert, 32'h7FFF_FFFF);

    settle();
    write_reg(RegTableSize, 11'd7);
    write_reg(RegProbeStep, 11'd3);
    issue(ModeFind, 32'd5);
    issue(ModeInsert, 32'd0);
    issue(ModeInsert, 32'd7);
    issue(ModeInsert, 32'h8000_0000);
    issue(ModeInsert, 32'h7FFF_FFFF);
    issue(ModeInsert, 32'hFFFF_FFFF);
    issue(ModeInsert, 32'd7);
    issue(ModeFind, 32'd7);
    issue(ModeDelete, 32'd0);
    issue(ModeFind, 32'd7);
    issue(ModeDelete, 32'd0);
    issue(ModeInsert, 32'd14);
    issue(ModeInsert, 32'd21);
    issue(ModeInsert, 32'd28);
    issue(ModeInsert, 32'd35);
    issue(ModeFind, 32'd56);
    issue(ModeClear, 32'hDEAD_BEEF);

    // A step that divides the size leaves most slots out of reach.
    settle();
    write_reg(RegTableSize, 11'd8);
    write_reg(RegProbeStep, 11'd4);
    issue(ModeFind, 32'd0);
    issue(ModeInsert, 32'd0);
    issue(ModeInsert, 32'd8);
    issue(ModeInsert, 32'd16);
    issue(ModeFind, 32'd24);

    for (int p = 0; p < 18; p++) run_phase(phase_size[p], phase_step[p]);

    settle();
    repeat (1100) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
design/oah_pkg.sv
design/oah_mem.sv
design/oah_rem.sv
design/open_addressing_hash_set_unit.sv
tb/sv/oah_checker.sv
tb/sv/tb.sv
